@@ design/hfcc_pkg.sv @@
package hfcc_pkg;

    localparam int TEMP_W   = 15;
    localparam int HUMI_W   = 14;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 3;

    localparam int T_PROD_W = 31;
    localparam int H_PROD_W = 30;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [TEMP_W-1:0]        TEMP_SPAN   = 15'd17500;
    localparam logic [HUMI_W-1:0]        HUMI_SPAN   = 14'd10000;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 15'sd4500;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN    = -15'sd4500;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 15'sd13000;
    localparam logic [HUMI_W-1:0]        HUMI_MAX    = 14'd10000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUMI_CRC = 2'd2
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] humi_word;
        t_status           status;
    } t_frame;

    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/humidity_frame_check_convert.sv @@
// Checks and converts a six-byte humidity and temperature measurement frame.
// The input channel carries one frame byte per word: temperature high, low
// and CRC, then humidity high, low and CRC. Raising the start flag with a
// byte makes it the first byte of a new frame and drops any partial frame.
// Without the flag, bytes keep counting and frames may follow back to back.
// The output channel carries one word per complete frame: temperature in
// hundredths of a degree, humidity in hundredths of a percent and a status
// code; both values read zero when either CRC is wrong.
// One byte is accepted in every cycle unless the receiver holds off a word.
// The result of a frame passes the frame register, which loads at the
// accepting edge, then the constant multiplications and the scaling, which
// each take one further register stage.
// A synchronous reset clears the byte position, the CRC and all valid flags.
// While the receiver holds off a presented word, the whole pipeline holds
// and input ready falls; it stays high whenever the output register is empty.
module humidity_frame_check_convert (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [hfcc_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                i_frame_start,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [hfcc_pkg::TEMP_W-1:0]  o_temperature_centideg,
    output logic [hfcc_pkg::HUMI_W-1:0]         o_humidity_centipct,
    output logic [hfcc_pkg::STATUS_W-1:0]       o_frame_status
);
    import hfcc_pkg::*;

    logic   advance;
    logic   accept;
    logic   frame_valid;
    t_frame frame;

    assign advance    = !o_out_valid || i_out_ready;
    assign accept     = i_in_valid && advance;
    assign o_in_ready = advance;

    hfcc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_advance     (advance),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_valid       (frame_valid),
        .o_frame       (frame)
    );

    hfcc_convert u_convert (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_advance              (advance),
        .i_valid                (frame_valid),
        .i_frame                (frame),
        .o_valid                (o_out_valid),
        .o_temperature_centideg (o_temperature_centideg),
        .o_humidity_centipct    (o_humidity_centipct),
        .o_frame_status         (o_frame_status)
    );

endmodule

@@ design/hfcc_frame.sv @@
module hfcc_frame (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_advance,
    input  logic [hfcc_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_frame_start,
    output logic                         o_valid,
    output hfcc_pkg::t_frame             o_frame
);
    import hfcc_pkg::*;

    localparam logic [POS_W-1:0] POS_TEMP_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_HUMI_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_HUMI_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_HUMI_CRC = 3'd5;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [WORD_W-1:0] r_temp, n_temp;
    logic [WORD_W-1:0] r_humi, n_humi;
    logic              r_tbad, n_tbad;
    logic              r_valid, n_valid;
    t_frame            r_frame, n_frame;

    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] crc_in;

    always_comb begin
        if (i_frame_start || r_pos > POS_HUMI_CRC) begin
            pos    = POS_TEMP_HI;
            crc_in = CRC_INIT;
        end else begin
            pos    = r_pos;
            crc_in = r_crc;
        end

        n_pos   = r_pos;
        n_crc   = r_crc;
        n_temp  = r_temp;
        n_humi  = r_humi;
        n_tbad  = r_tbad;
        n_valid = r_valid;
        n_frame = r_frame;

        if (i_advance) begin
            n_valid = 1'b0;
        end

        if (i_accept) begin
            n_pos = pos + 3'd1;
            case (pos)
                POS_TEMP_HI, POS_TEMP_LO: begin
                    n_temp = {r_temp[BYTE_W-1:0], i_data_byte};
                    n_crc  = crc8_byte(crc_in, i_data_byte);
                end
                POS_TEMP_CRC: begin
                    n_tbad = (crc_in != i_data_byte);
                    n_crc  = CRC_INIT;
                end
                POS_HUMI_HI, POS_HUMI_LO: begin
                    n_humi = {r_humi[BYTE_W-1:0], i_data_byte};
                    n_crc  = crc8_byte(crc_in, i_data_byte);
                end
                default: begin
                    n_valid           = 1'b1;
                    n_frame.temp_word = r_temp;
                    n_frame.humi_word = r_humi;
                    if (r_tbad) begin
                        n_frame.status = ST_TEMP_CRC;
                    end else if (crc_in != i_data_byte) begin
                        n_frame.status = ST_HUMI_CRC;
                    end else begin
                        n_frame.status = ST_OK;
                    end
                    n_pos = POS_TEMP_HI;
                    n_crc = CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_TEMP_HI;
            r_crc   <= CRC_INIT;
            r_temp  <= '0;
            r_humi  <= '0;
            r_tbad  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_temp  <= n_temp;
            r_humi  <= n_humi;
            r_tbad  <= n_tbad;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

@@ design/hfcc_convert.sv @@
module hfcc_convert (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic                                i_valid,
    input  hfcc_pkg::t_frame                    i_frame,
    output logic                                o_valid,
    output logic signed [hfcc_pkg::TEMP_W-1:0]  o_temperature_centideg,
    output logic [hfcc_pkg::HUMI_W-1:0]         o_humidity_centipct,
    output logic [hfcc_pkg::STATUS_W-1:0]       o_frame_status
);
    import hfcc_pkg::*;

    logic                       r_prod_valid;
    logic [T_PROD_W-1:0]        r_t_prod;
    logic [H_PROD_W-1:0]        r_h_prod;
    t_status                    r_prod_status;

    logic                       r_out_valid;
    logic signed [TEMP_W-1:0]   r_temp, n_temp;
    logic [HUMI_W-1:0]          r_humi, n_humi;
    t_status                    r_status;

    logic [T_PROD_W:0]          t_sum;
    logic [H_PROD_W:0]          h_sum;
    logic [TEMP_W-1:0]          t_q;
    logic [HUMI_W-1:0]          h_q;

    // Division by 65535 as a shift-and-add: valid while the quotient fits in 16 bits.
    always_comb begin
        t_sum = {1'b0, r_t_prod} + (T_PROD_W + 1)'(r_t_prod >> WORD_W)
              + (T_PROD_W + 1)'(1);
        h_sum = {1'b0, r_h_prod} + (H_PROD_W + 1)'(r_h_prod >> WORD_W)
              + (H_PROD_W + 1)'(1);
        t_q   = t_sum[WORD_W+TEMP_W-1:WORD_W];
        h_q   = h_sum[WORD_W+HUMI_W-1:WORD_W];
        if (r_prod_status == ST_OK) begin
            n_temp = $signed(t_q) - TEMP_OFFSET;
            n_humi = h_q;
        end else begin
            n_temp = '0;
            n_humi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_advance) begin
            r_prod_valid <= i_valid;
            r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_t_prod      <= T_PROD_W'(i_frame.temp_word) * T_PROD_W'(TEMP_SPAN);
            r_h_prod      <= H_PROD_W'(i_frame.humi_word) * H_PROD_W'(HUMI_SPAN);
            r_prod_status <= i_frame.status;
            r_temp        <= n_temp;
            r_humi        <= n_humi;
            r_status      <= r_prod_status;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_temperature_centideg = r_temp;
    assign o_humidity_centipct    = r_humi;
    assign o_frame_status         = r_status;

endmodule

@@ design/hfcc_checker.sv @@
module hfcc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic [hfcc_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                i_frame_start,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [hfcc_pkg::TEMP_W-1:0]  o_temperature_centideg,
    input  logic [hfcc_pkg::HUMI_W-1:0]         o_humidity_centipct,
    input  logic [hfcc_pkg::STATUS_W-1:0]       o_frame_status
);
    import hfcc_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid straight after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_temperature_centideg)
            && $stable(o_humidity_centipct) && $stable(o_frame_status))
        else $error("stalled output word changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input held off with an empty output register");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status != ST_OK |->
            o_temperature_centideg == '0 && o_humidity_centipct == '0)
        else $error("values not zero on a CRC error");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status == ST_OK |->
            o_temperature_centideg >= TEMP_MIN && o_temperature_centideg <= TEMP_MAX
            && o_humidity_centipct <= HUMI_MAX)
        else $error("converted value out of range");

endmodule

bind humidity_frame_check_convert hfcc_checker u_hfcc_checker (.*);
